[hw/rtl/tnpp_pkg.sv]
// shared types and constants of the spectral peak picker
`timescale 1ns / 1ps
package tnpp_pkg;

	localparam int CFG_W     = 5;
	localparam int CFG_IDX_W = 1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PEAK_COUNT    = 1'b0,
		REG_NEIGHBOR_SPAN = 1'b1
	} cfg_reg_t;

	localparam logic [CFG_W-1:0] PEAK_COUNT_RST    = 5'd8;
	localparam logic [CFG_W-1:0] NEIGHBOR_SPAN_RST = 5'd4;

	typedef struct packed {
		logic ins;
		logic pop;
	} list_ctrl_t;

endpackage

[hw/rtl/tnpp_win_cell.sv]
// one tap of the magnitude window with its neighbor compare
`timescale 1ns / 1ps
module tnpp_win_cell #(
	parameter int MAG_BITS = 24
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                shift,
	input  logic [MAG_BITS-1:0] din,
	input  logic [MAG_BITS-1:0] cand,
	input  logic                in_range,
	output logic [MAG_BITS-1:0] q,
	output logic                fail
);

	logic [MAG_BITS-1:0] mag_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mag_q <= '0;
		end else if (shift) begin
			mag_q <= din;
		end
	end

	assign q    = mag_q;
	// candidate does not beat this neighbor
	assign fail = in_range && (cand <= mag_q);

endmodule

[hw/rtl/tnpp_list_cell.sv]
// one entry of the sorted peak list with insert and pop moves
`timescale 1ns / 1ps
module tnpp_list_cell #(
	parameter int BIN_W    = 12,
	parameter int MAG_BITS = 24
) (
	input  logic                       clk,
	input  tnpp_pkg::list_ctrl_t       ctrl,
	input  logic                       valid,
	input  logic [BIN_W-1:0]           new_bin,
	input  logic [MAG_BITS-1:0]        new_mag,
	input  logic [BIN_W-1:0]           left_bin,
	input  logic [MAG_BITS-1:0]        left_mag,
	input  logic                       left_beat,
	input  logic [BIN_W-1:0]           right_bin,
	input  logic [MAG_BITS-1:0]        right_mag,
	output logic [BIN_W-1:0]           bin,
	output logic [MAG_BITS-1:0]        mag,
	output logic                       beat
);

	import tnpp_pkg::*;

	logic [BIN_W-1:0]    bin_q;
	logic [MAG_BITS-1:0] mag_q;

	// new peak ranks above this entry, or the entry is empty
	assign beat = !valid || (new_mag > mag_q) || ((new_mag == mag_q) && (new_bin < bin_q));

	always_ff @(posedge clk) begin
		if (ctrl.ins && beat) begin
			if (left_beat) begin
				bin_q <= left_bin;
				mag_q <= left_mag;
			end else begin
				bin_q <= new_bin;
				mag_q <= new_mag;
			end
		end else if (ctrl.pop) begin
			bin_q <= right_bin;
			mag_q <= right_mag;
		end
	end

	assign bin = bin_q;
	assign mag = mag_q;

endmodule

[hw/rtl/top_n_spectral_peak_picker.sv]
// top level of the top-n spectral peak picker
//
// Bins of one frame enter on the in channel (in_valid/in_ready) in bin order,
// one per cycle, with last_bin on the final bin. Each bin shifts into a row of
// window cells; a bin is tested once its span of later bins has arrived, in the
// cycle after the last of them enters, and a peak is inserted into a row of list
// cells in the following cycle, all list cells comparing against it in parallel.
// Throughput within a frame is one bin per cycle. After the last bin is taken
// in_ready stays low; once its last_bin flag has passed the test pipeline
// registers and the pick state, results are loaded into the output register,
// one per cycle while out_ready is high, largest peak first, last_peak on the
// final one. A frame with no peak gives one item with found low. in_ready rises
// with the loading of the final result, so the next frame overlaps its delivery.
// A stalled receiver holds the output register and pauses the list unload.
// Reset clears the window, bin counter, list fill and pipeline, and loads
// peak_count 8 and neighbor_span 4. Configuration writes take effect at once.
`timescale 1ns / 1ps
module top_n_spectral_peak_picker #(
	parameter int MAX_BINS  = 4096,
	parameter int MAX_SPAN  = 20,
	parameter int MAX_PEAKS = 20,
	parameter int MAG_BITS  = 24
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_write,
	input  logic [tnpp_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [tnpp_pkg::CFG_W-1:0]          cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [MAG_BITS-1:0]                 magnitude,
	input  logic                                last_bin,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [$clog2(MAX_BINS)-1:0]         peak_bin,
	output logic [MAG_BITS-1:0]                 peak_magnitude,
	output logic                                found,
	output logic                                last_peak
);

	import tnpp_pkg::*;

	localparam int BIN_W   = $clog2(MAX_BINS);
	localparam int SPAN_W  = $clog2(MAX_SPAN + 1);
	localparam int WIN_LEN = 2 * MAX_SPAN + 1;
	localparam int WIN_IW  = $clog2(WIN_LEN);
	localparam int FILL_W  = $clog2(MAX_PEAKS + 1);

	typedef enum logic [1:0] {
		S_RUN,
		S_PICK,
		S_EMIT
	} state_t;

	state_t state_q;

	logic [CFG_W-1:0]    peak_count_q;
	logic [CFG_W-1:0]    span_q;
	logic [SPAN_W-1:0]   span_eff;
	logic [FILL_W-1:0]   want;
	logic [FILL_W-1:0]   cnt;

	logic                accept;
	logic                busy_q;
	logic [BIN_W-1:0]    bin_q;

	logic                valid_s1;
	logic                last_s1;
	logic [BIN_W-1:0]    bin_s1;
	logic                peak_s2;
	logic                last_s2;
	logic [BIN_W-1:0]    pbin_s2;
	logic [MAG_BITS-1:0] pmag_s2;

	logic [MAG_BITS-1:0] win_q [WIN_LEN];
	logic [WIN_LEN-1:0]  in_range;
	logic [WIN_LEN-1:0]  fail;
	logic [MAG_BITS-1:0] cand;
	logic                test_ok;

	logic [BIN_W-1:0]    lbin [MAX_PEAKS];
	logic [MAG_BITS-1:0] lmag [MAX_PEAKS];
	logic [MAX_PEAKS-1:0] beat;
	list_ctrl_t          lctrl;
	logic [FILL_W-1:0]   fill_q;

	logic [FILL_W-1:0]   remain_q;
	logic                none_q;
	logic                slot_free;
	logic                emit;
	logic                done;

	logic                out_valid_q;
	logic [BIN_W-1:0]    out_bin_q;
	logic [MAG_BITS-1:0] out_mag_q;
	logic                found_q;
	logic                last_peak_q;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peak_count_q <= PEAK_COUNT_RST;
			span_q       <= NEIGHBOR_SPAN_RST;
		end else if (cfg_write) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_PEAK_COUNT:    peak_count_q <= cfg_data;
				REG_NEIGHBOR_SPAN: span_q       <= cfg_data;
			endcase
		end
	end

	always_comb begin
		if (int'(span_q) > MAX_SPAN) begin
			span_eff = SPAN_W'(MAX_SPAN);
		end else begin
			span_eff = SPAN_W'(span_q);
		end
		if (peak_count_q == '0) begin
			want = FILL_W'(1);
		end else if (int'(peak_count_q) > MAX_PEAKS) begin
			want = FILL_W'(MAX_PEAKS);
		end else begin
			want = FILL_W'(peak_count_q);
		end
		cnt = (fill_q < want) ? fill_q : want;
	end

	assign in_ready = !busy_q;
	assign accept   = in_valid && in_ready;

	// bin counter and test pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_q    <= '0;
			valid_s1 <= 1'b0;
			last_s1  <= 1'b0;
			bin_s1   <= '0;
			peak_s2  <= 1'b0;
			last_s2  <= 1'b0;
			pbin_s2  <= '0;
			pmag_s2  <= '0;
		end else begin
			if (accept) begin
				if (last_bin || (int'(bin_q) == MAX_BINS - 1)) begin
					bin_q <= '0;
				end else begin
					bin_q <= bin_q + 1'b1;
				end
				bin_s1 <= bin_q;
			end
			valid_s1 <= accept;
			last_s1  <= accept && last_bin;
			peak_s2  <= valid_s1 && test_ok;
			last_s2  <= last_s1;
			pbin_s2  <= bin_s1 - BIN_W'(span_eff);
			pmag_s2  <= cand;
		end
	end

	// window row
	assign cand    = win_q[WIN_IW'(span_eff)];
	assign test_ok = (int'(bin_s1) >= 2 * int'(span_eff)) && !(|fail);

	for (genvar k = 0; k < WIN_LEN; k++) begin : g_win
		logic [MAG_BITS-1:0] din;

		if (k == 0) begin : g_head
			assign din = magnitude;
		end else begin : g_tail
			assign din = win_q[k-1];
		end

		assign in_range[k] = (k <= 2 * int'(span_eff)) && (k != int'(span_eff));

		tnpp_win_cell #(
			.MAG_BITS(MAG_BITS)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.shift   (accept),
			.din     (din),
			.cand    (cand),
			.in_range(in_range[k]),
			.q       (win_q[k]),
			.fail    (fail[k])
		);
	end

	// sorted list row
	assign lctrl.ins = peak_s2;
	assign lctrl.pop = emit && !none_q;

	for (genvar i = 0; i < MAX_PEAKS; i++) begin : g_list
		logic [BIN_W-1:0]    left_bin;
		logic [MAG_BITS-1:0] left_mag;
		logic                left_beat;
		logic [BIN_W-1:0]    right_bin;
		logic [MAG_BITS-1:0] right_mag;

		if (i == 0) begin : g_first
			assign left_bin  = '0;
			assign left_mag  = '0;
			assign left_beat = 1'b0;
		end else begin : g_rest
			assign left_bin  = lbin[i-1];
			assign left_mag  = lmag[i-1];
			assign left_beat = beat[i-1];
		end

		if (i == MAX_PEAKS - 1) begin : g_end
			assign right_bin = '0;
			assign right_mag = '0;
		end else begin : g_mid
			assign right_bin = lbin[i+1];
			assign right_mag = lmag[i+1];
		end

		tnpp_list_cell #(
			.BIN_W   (BIN_W),
			.MAG_BITS(MAG_BITS)
		) u_cell (
			.clk      (clk),
			.ctrl     (lctrl),
			.valid    (int'(fill_q) > i),
			.new_bin  (pbin_s2),
			.new_mag  (pmag_s2),
			.left_bin (left_bin),
			.left_mag (left_mag),
			.left_beat(left_beat),
			.right_bin(right_bin),
			.right_mag(right_mag),
			.bin      (lbin[i]),
			.mag      (lmag[i]),
			.beat     (beat[i])
		);
	end

	// unload control
	assign slot_free = !out_valid_q || out_ready;
	assign emit      = (state_q == S_EMIT) && slot_free;
	assign done      = emit && (none_q || (remain_q == FILL_W'(1)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_RUN;
			busy_q      <= 1'b0;
			fill_q      <= '0;
			remain_q    <= '0;
			none_q      <= 1'b0;
			out_valid_q <= 1'b0;
			out_bin_q   <= '0;
			out_mag_q   <= '0;
			found_q     <= 1'b0;
			last_peak_q <= 1'b0;
		end else begin
			if (accept && last_bin) begin
				busy_q <= 1'b1;
			end
			if (peak_s2 && (int'(fill_q) < MAX_PEAKS)) begin
				fill_q <= fill_q + 1'b1;
			end
			if (out_valid_q && out_ready && !emit) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_RUN: begin
					if (last_s2) begin
						state_q <= S_PICK;
					end
				end
				S_PICK: begin
					remain_q <= cnt;
					none_q   <= (cnt == '0);
					state_q  <= S_EMIT;
				end
				S_EMIT: begin
					if (emit) begin
						out_valid_q <= 1'b1;
						if (none_q) begin
							out_bin_q   <= '0;
							out_mag_q   <= '0;
							found_q     <= 1'b0;
							last_peak_q <= 1'b1;
						end else begin
							out_bin_q   <= lbin[0];
							out_mag_q   <= lmag[0];
							found_q     <= 1'b1;
							last_peak_q <= (remain_q == FILL_W'(1));
							remain_q    <= remain_q - 1'b1;
						end
					end
					if (done) begin
						fill_q  <= '0;
						busy_q  <= 1'b0;
						state_q <= S_RUN;
					end
				end
				default: state_q <= S_RUN;
			endcase
		end
	end

	assign out_valid      = out_valid_q;
	assign peak_bin       = out_bin_q;
	assign peak_magnitude = out_mag_q;
	assign found          = found_q;
	assign last_peak      = last_peak_q;

	// checks
	a_none_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !found) |-> last_peak)
		else $error("empty frame item without last_peak");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(fill_q) <= MAX_PEAKS)
		else $error("peak list fill out of range");

	a_no_input_while_unloading: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_RUN) |-> !in_ready)
		else $error("input taken during list unload");

	a_emit_has_entries: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && !none_q) |-> (remain_q != '0) && (fill_q != '0))
		else $error("unload from empty list");

endmodule

[bench/peak_list_checker.sv]
// checker: predicts the peaks reported for each frame and compares them with the block's output
`timescale 1ns / 1ps
module peak_list_checker #(
	parameter int MAX_BINS  = 4096,
	parameter int MAX_SPAN  = 20,
	parameter int MAX_PEAKS = 20,
	parameter int MAG_BITS  = 24
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_write,
	input  logic [tnpp_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [tnpp_pkg::CFG_W-1:0]        cfg_data,
	input  logic                              in_valid,
	input  logic                              in_ready,
	input  logic [MAG_BITS-1:0]               magnitude,
	input  logic                              last_bin,
	input  logic                              out_valid,
	input  logic                              out_ready,
	input  logic [$clog2(MAX_BINS)-1:0]       peak_bin,
	input  logic [MAG_BITS-1:0]               peak_magnitude,
	input  logic                              found,
	input  logic                              last_peak,
	output int                                pending,
	output int                                fail_count
);
	localparam int BIN_W = $clog2(MAX_BINS);
	localparam int WIN   = 2 * MAX_SPAN + 1;

	typedef struct packed {
		logic [BIN_W-1:0]    pbin;
		logic [MAG_BITS-1:0] pmag;
		logic                pfound;
		logic                plast;
	} peak_t;

	logic [MAG_BITS-1:0]         recent_mags [WIN];
	logic [BIN_W-1:0]            bin_pos;
	logic [BIN_W-1:0]            top_bins [MAX_PEAKS];
	logic [MAG_BITS-1:0]         top_mags [MAX_PEAKS];
	int                          top_fill;
	logic [tnpp_pkg::CFG_W-1:0]  report_count;
	logic [tnpp_pkg::CFG_W-1:0]  span_setting;
	peak_t                       awaited_peaks [$];
	peak_t                       head;

	function automatic bit ranks_higher(input logic [MAG_BITS-1:0] ma, input logic [BIN_W-1:0] ba,
			input logic [MAG_BITS-1:0] mb, input logic [BIN_W-1:0] bb);
		return ma > mb || (ma == mb && ba < bb);
	endfunction

	task automatic insert_peak(input logic [BIN_W-1:0] b, input logic [MAG_BITS-1:0] m);
		int pos;
		int k;
		pos = 0;
		while (pos < top_fill && !ranks_higher(m, b, top_mags[pos], top_bins[pos]))
			pos++;
		if (pos < MAX_PEAKS) begin
			k = (top_fill < MAX_PEAKS) ? top_fill : MAX_PEAKS - 1;
			while (k > pos) begin
				top_bins[k] = top_bins[k - 1];
				top_mags[k] = top_mags[k - 1];
				k--;
			end
			top_bins[pos] = b;
			top_mags[pos] = m;
			if (top_fill < MAX_PEAKS)
				top_fill++;
		end
	endtask

	task automatic scan_bin(input logic [MAG_BITS-1:0] m, input logic is_last);
		int                  span;
		int                  c;
		int                  want;
		int                  cnt;
		logic [MAG_BITS-1:0] cand;
		logic                is_peak;
		peak_t               p;
		span = (span_setting > MAX_SPAN) ? MAX_SPAN : int'(span_setting);
		c = int'(bin_pos);
		for (int k = WIN - 1; k > 0; k--)
			recent_mags[k] = recent_mags[k - 1];
		recent_mags[0] = m;
		if (c >= 2 * span) begin
			cand = recent_mags[span];
			is_peak = 1'b1;
			for (int k = 1; k <= span; k++)
				if (cand <= recent_mags[span - k] || cand <= recent_mags[span + k])
					is_peak = 1'b0;
			if (is_peak)
				insert_peak(BIN_W'(c - span), cand);
		end
		bin_pos = (c + 1 >= MAX_BINS) ? '0 : BIN_W'(c + 1);
		if (is_last) begin
			if (report_count == 0)
				want = 1;
			else if (report_count > MAX_PEAKS)
				want = MAX_PEAKS;
			else
				want = int'(report_count);
			cnt = (top_fill < want) ? top_fill : want;
			if (cnt == 0) begin
				p = '{pbin: '0, pmag: '0, pfound: 1'b0, plast: 1'b1};
				awaited_peaks = {awaited_peaks, p};
			end
			for (int k = 0; k < cnt; k++) begin
				p = '{pbin: top_bins[k], pmag: top_mags[k], pfound: 1'b1, plast: (k == cnt - 1)};
				awaited_peaks = {awaited_peaks, p};
			end
			bin_pos = '0;
			top_fill = 0;
		end
	endtask

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("%0t peak check failed, %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
		fail_count = fail_count + 1;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			recent_mags = '{default: '0};
			bin_pos = '0;
			top_fill = 0;
			report_count = tnpp_pkg::PEAK_COUNT_RST;
			span_setting = tnpp_pkg::NEIGHBOR_SPAN_RST;
			awaited_peaks.delete();
			fail_count = 0;
			pending <= 0;
		end else begin
			if (in_valid && in_ready)
				scan_bin(magnitude, last_bin);
			if (cfg_write) begin
				case (tnpp_pkg::cfg_reg_t'(cfg_index))
					tnpp_pkg::REG_PEAK_COUNT: report_count = cfg_data;
					tnpp_pkg::REG_NEIGHBOR_SPAN: span_setting = cfg_data;
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				if (awaited_peaks.size() == 0) begin
					report_mismatch("item with nothing expected, bin", peak_bin, 0);
				end else begin
					head = awaited_peaks.pop_front();
					if (peak_bin !== head.pbin)
						report_mismatch("peak_bin", peak_bin, head.pbin);
					if (peak_magnitude !== head.pmag)
						report_mismatch("peak_magnitude", peak_magnitude, head.pmag);
					if (found !== head.pfound)
						report_mismatch("found", found, head.pfound);
					if (last_peak !== head.plast)
						report_mismatch("last_peak", last_peak, head.plast);
				end
			end
			pending <= awaited_peaks.size();
		end
	end

endmodule

[bench/testbench.sv]
// testbench top: drives frames of bins and register settings into the peak picker
`timescale 1ns / 1ps
module testbench;
	localparam int MAG_W         = 24;
	localparam int BIN_W         = 12;
	localparam int RANDOM_BINS   = 360;
	localparam int QUIET_LIMIT   = 400;
	localparam int SETTLE_CYCLES = 6;

	logic                             clk = 1'b0;
	logic                             arst_n;
	logic                             cfg_write;
	logic [tnpp_pkg::CFG_IDX_W-1:0]   cfg_index;
	logic [tnpp_pkg::CFG_W-1:0]       cfg_data;
	logic                             in_valid;
	logic                             in_ready;
	logic [MAG_W-1:0]                 magnitude;
	logic                             last_bin;
	logic                             out_valid;
	logic                             out_ready;
	logic [BIN_W-1:0]                 peak_bin;
	logic [MAG_W-1:0]                 peak_magnitude;
	logic                             found;
	logic                             last_peak;
	int                               pending;
	int                               fail_count;
	int                               quiet_cycles = 0;
	bit                               gap_on = 1'b1;
	bit                               stall_on = 1'b1;
	logic [MAG_W-1:0]                 frame_mags [$];

	top_n_spectral_peak_picker u_top (.*);

	peak_list_checker u_checker (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic logic [MAG_W-1:0] pick_mag(input int kind, input int idx);
		case (kind)
			0: return MAG_W'($urandom);
			1: return MAG_W'($urandom_range(0, 7));
			2: return (idx % 2 != 0) ? MAG_W'($urandom_range(1, 'hFFFFFF))
				: MAG_W'($urandom_range(0, 3));
			default: begin
				case ($urandom_range(0, 2))
					0: return '0;
					1: return '1;
					default: return MAG_W'($urandom);
				endcase
			end
		endcase
	endfunction

	function automatic logic [tnpp_pkg::CFG_W-1:0] pick_reg_value();
		case ($urandom_range(0, 5))
			0: return 5'd0;
			1: return 5'd1;
			2: return 5'd20;
			3: return 5'd31;
			default: return tnpp_pkg::CFG_W'($urandom_range(0, 31));
		endcase
	endfunction

	task automatic build_frame(input int kind, input int len);
		frame_mags.delete();
		for (int i = 0; i < len; i++)
			frame_mags = {frame_mags, pick_mag(kind, i)};
	endtask

	task automatic send_bin(input logic [MAG_W-1:0] m, input logic l);
		int gap;
		gap = gap_on ? $urandom_range(0, 11) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		magnitude <= m;
		last_bin  <= l;
		@(posedge clk iff in_ready);
	endtask

	task automatic send_frame();
		foreach (frame_mags[i])
			send_bin(frame_mags[i], i == frame_mags.size() - 1);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk iff pending == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_config(input logic [tnpp_pkg::CFG_W-1:0] count,
			input logic [tnpp_pkg::CFG_W-1:0] span);
		cfg_write <= 1'b1;
		cfg_index <= tnpp_pkg::REG_PEAK_COUNT;
		cfg_data  <= count;
		@(posedge clk);
		cfg_index <= tnpp_pkg::REG_NEIGHBOR_SPAN;
		cfg_data  <= span;
		@(posedge clk);
		cfg_write <= 1'b0;
	endtask

	initial begin
		int stall;
		out_ready <= 1'b0;
		@(posedge clk iff arst_n);
		forever begin
			stall = stall_on ? $urandom_range(0, 11) : 0;
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk iff out_valid);
		end
	end

	initial begin
		int                          span_eff;
		int                          len;
		int                          kind;
		int                          phase;
		int                          bins_sent;
		logic [tnpp_pkg::CFG_W-1:0]  count_v;
		logic [tnpp_pkg::CFG_W-1:0]  span_v;
		arst_n    <= 1'b0;
		cfg_write <= 1'b0;
		cfg_index <= tnpp_pkg::REG_PEAK_COUNT;
		cfg_data  <= '0;
		in_valid  <= 1'b0;
		magnitude <= '0;
		last_bin  <= 1'b0;
		bins_sent = 0;
		phase = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// lone maximum under reset settings, then a frame too short for any peak
		frame_mags = '{24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'hFFFFFF,
			24'h0, 24'h0, 24'h0, 24'h0};
		send_frame();
		frame_mags = '{24'h0, 24'h0, 24'h0};
		send_frame();
		settle();

		// zero span makes every bin a peak, zero count reports one
		set_config(5'd0, 5'd0);
		frame_mags = '{24'd5, 24'd5, 24'd9, 24'd1};
		send_frame();
		settle();

		// oversized count, equal peaks ordered by bin
		set_config(5'd31, 5'd1);
		frame_mags = '{24'd1, 24'h555555, 24'd1, 24'hAAAAAA, 24'd1, 24'h555555,
			24'd0, 24'd1};
		send_frame();
		settle();

		while (bins_sent < RANDOM_BINS) begin
			case (phase)
				0: begin
					count_v = 5'd1;
					span_v  = 5'd31;
				end
				1: begin
					count_v = 5'd20;
					span_v  = 5'd20;
				end
				default: begin
					count_v = pick_reg_value();
					span_v  = pick_reg_value();
				end
			endcase
			set_config(count_v, span_v);
			span_eff = (span_v > 20) ? 20 : int'(span_v);
			gap_on   = $urandom_range(0, 3) != 0;
			stall_on = $urandom_range(0, 3) != 0;
			repeat ($urandom_range(1, 4)) begin
				kind = $urandom_range(0, 3);
				if (kind == 2 && $urandom_range(0, 1) == 1)
					len = $urandom_range(40, 70);
				else
					len = $urandom_range(1, 2 * span_eff + 24);
				build_frame(kind, len);
				send_frame();
				bins_sent += len;
			end
			settle();
			phase++;
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (pending != 0)
			$display("%0d expected peaks never arrived", pending);
		if (fail_count == 0 && pending == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

[sim.f]
hw/rtl/tnpp_pkg.sv
hw/rtl/tnpp_win_cell.sv
hw/rtl/tnpp_list_cell.sv
hw/rtl/top_n_spectral_peak_picker.sv
bench/peak_list_checker.sv
bench/testbench.sv
